// File: rtl/dqr_pkg.sv
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared types and constants for the double-ended queue with reverse.
// ----------------------------------------------------------------------------
package dqr_pkg;

  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_REVERSE    = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] push_value;
  } req_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
  } rsp_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WAIT_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_LOW,
    OP_PUSH_HIGH,
    OP_POP_LOW,
    OP_POP_HIGH,
    OP_REVERSE
  } op_t;

  // controller to datapath
  typedef struct packed {
    op_t        op;
    logic       hold_load;
    logic       hold_from_rdata;
    logic [1:0] hold_status;
    logic       out_load;
    logic       out_from_rdata;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic reversed;
  } stat_t;

endpackage

// File: rtl/dqr_ctrl.sv
// ----------------------------------------------------------------------------
// dqr_ctrl
// Controller: decodes commands, sequences the memory read of a pop and
// hands results to the output register.
// ----------------------------------------------------------------------------
module dqr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [2:0]       command,
  input  logic             rsp_stall,
  input  dqr_pkg::stat_t   stat,
  output logic             req_stall,
  output logic             rsp_valid,
  output dqr_pkg::state_t  state,
  output dqr_pkg::ctrl_t   ctrl
);

  dqr_pkg::state_t state_next;
  logic            rsp_valid_next;
  logic            accept;
  logic            out_free;
  logic            front_cmd;

  assign req_stall = (state != dqr_pkg::S_IDLE);
  assign accept    = req_valid && (state == dqr_pkg::S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  // front end is the physical low end unless reversed
  assign front_cmd = (command == dqr_pkg::CMD_PUSH_FRONT) ||
                     (command == dqr_pkg::CMD_POP_FRONT);

  always_comb begin
    state_next = state;
    case (state)
      dqr_pkg::S_IDLE: begin
        if (accept) begin
          case (command)
            dqr_pkg::CMD_PUSH_FRONT, dqr_pkg::CMD_PUSH_BACK: begin
              if (stat.full) state_next = dqr_pkg::S_WAIT_OUT;
            end
            dqr_pkg::CMD_POP_FRONT, dqr_pkg::CMD_POP_BACK: begin
              state_next = stat.empty ? dqr_pkg::S_WAIT_OUT : dqr_pkg::S_READ;
            end
            default: state_next = dqr_pkg::S_IDLE;
          endcase
        end
      end
      dqr_pkg::S_READ: begin
        state_next = out_free ? dqr_pkg::S_IDLE : dqr_pkg::S_WAIT_OUT;
      end
      dqr_pkg::S_WAIT_OUT: begin
        if (out_free) state_next = dqr_pkg::S_IDLE;
      end
      default: state_next = dqr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '{op: dqr_pkg::OP_NONE, hold_load: 1'b0, hold_from_rdata: 1'b0,
             hold_status: dqr_pkg::STATUS_OK, out_load: 1'b0, out_from_rdata: 1'b0};
    case (state)
      dqr_pkg::S_IDLE: begin
        if (accept) begin
          case (command)
            dqr_pkg::CMD_PUSH_FRONT, dqr_pkg::CMD_PUSH_BACK: begin
              if (stat.full) begin
                ctrl.hold_load   = 1'b1;
                ctrl.hold_status = dqr_pkg::STATUS_FULL;
              end else if (front_cmd != stat.reversed) begin
                ctrl.op = dqr_pkg::OP_PUSH_LOW;
              end else begin
                ctrl.op = dqr_pkg::OP_PUSH_HIGH;
              end
            end
            dqr_pkg::CMD_POP_FRONT, dqr_pkg::CMD_POP_BACK: begin
              if (stat.empty) begin
                ctrl.hold_load   = 1'b1;
                ctrl.hold_status = dqr_pkg::STATUS_EMPTY;
              end else if (front_cmd != stat.reversed) begin
                ctrl.op = dqr_pkg::OP_POP_LOW;
              end else begin
                ctrl.op = dqr_pkg::OP_POP_HIGH;
              end
            end
            dqr_pkg::CMD_REVERSE: ctrl.op = dqr_pkg::OP_REVERSE;
            default: ctrl.op = dqr_pkg::OP_NONE;
          endcase
        end
      end
      dqr_pkg::S_READ: begin
        if (out_free) begin
          ctrl.out_load       = 1'b1;
          ctrl.out_from_rdata = 1'b1;
        end else begin
          // output still occupied, park the popped value
          ctrl.hold_load       = 1'b1;
          ctrl.hold_from_rdata = 1'b1;
        end
      end
      dqr_pkg::S_WAIT_OUT: begin
        ctrl.out_load = out_free;
      end
      default: ctrl.op = dqr_pkg::OP_NONE;
    endcase
  end

  assign rsp_valid_next = ctrl.out_load || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dqr_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// File: rtl/dqr_dpath.sv
// ----------------------------------------------------------------------------
// dqr_dpath
// Datapath: circular entry memory, end pointers, fill count, direction flag,
// result hold register and output payload register.
// ----------------------------------------------------------------------------
module dqr_dpath (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] push_value,
  input  dqr_pkg::ctrl_t     ctrl,
  output dqr_pkg::stat_t     stat,
  output dqr_pkg::rsp_item_t rsp
);

  localparam logic [dqr_pkg::PTR_W-1:0] PTR_LAST = dqr_pkg::PTR_W'(dqr_pkg::DEPTH - 1);
  localparam logic [dqr_pkg::CNT_W-1:0] CNT_FULL = dqr_pkg::CNT_W'(dqr_pkg::DEPTH);

  logic [31:0] mem [dqr_pkg::DEPTH];

  logic [dqr_pkg::PTR_W-1:0] front;
  logic [dqr_pkg::PTR_W-1:0] front_next;
  logic [dqr_pkg::PTR_W-1:0] back;
  logic [dqr_pkg::PTR_W-1:0] back_next;
  logic [dqr_pkg::CNT_W-1:0] count;
  logic [dqr_pkg::CNT_W-1:0] count_next;
  logic                      reversed;
  logic                      reversed_next;

  logic [dqr_pkg::PTR_W-1:0] front_inc;
  logic [dqr_pkg::PTR_W-1:0] front_dec;
  logic [dqr_pkg::PTR_W-1:0] back_inc;
  logic [dqr_pkg::PTR_W-1:0] back_dec;

  logic                      wr_en;
  logic [dqr_pkg::PTR_W-1:0] wr_addr;
  logic [dqr_pkg::PTR_W-1:0] rd_addr;
  logic [31:0]               rd_data;

  logic [1:0]                hold_status;
  logic [31:0]               hold_value;

  assign front_inc = (front == PTR_LAST) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? PTR_LAST : front - 1'b1;
  assign back_inc  = (back == PTR_LAST) ? '0 : back + 1'b1;
  assign back_dec  = (back == '0) ? PTR_LAST : back - 1'b1;

  assign stat.full     = (count == CNT_FULL);
  assign stat.empty    = (count == '0);
  assign stat.reversed = reversed;

  always_comb begin
    front_next    = front;
    back_next     = back;
    count_next    = count;
    reversed_next = reversed;
    wr_en         = 1'b0;
    wr_addr       = back;
    rd_addr       = front;
    case (ctrl.op)
      dqr_pkg::OP_PUSH_LOW: begin
        front_next = front_dec;
        wr_en      = 1'b1;
        wr_addr    = front_dec;
        count_next = count + 1'b1;
      end
      dqr_pkg::OP_PUSH_HIGH: begin
        back_next  = back_inc;
        wr_en      = 1'b1;
        wr_addr    = back;
        count_next = count + 1'b1;
      end
      dqr_pkg::OP_POP_LOW: begin
        front_next = front_inc;
        rd_addr    = front;
        count_next = count - 1'b1;
      end
      dqr_pkg::OP_POP_HIGH: begin
        back_next  = back_dec;
        rd_addr    = back_dec;
        count_next = count - 1'b1;
      end
      dqr_pkg::OP_REVERSE: reversed_next = !reversed;
      default: reversed_next = reversed;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      back     <= '0;
      count    <= '0;
      reversed <= 1'b0;
    end else begin
      front    <= front_next;
      back     <= back_next;
      count    <= count_next;
      reversed <= reversed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= push_value;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.hold_load) begin
      hold_status <= ctrl.hold_status;
      hold_value  <= ctrl.hold_from_rdata ? rd_data : '0;
    end
    if (ctrl.out_load) begin
      rsp.status    <= ctrl.out_from_rdata ? dqr_pkg::STATUS_OK : hold_status;
      rsp.pop_value <= ctrl.out_from_rdata ? rd_data : hold_value;
    end
  end

endmodule

// File: rtl/deque_with_reverse_top.sv
// ----------------------------------------------------------------------------
// deque_with_reverse_top
// Bounded double-ended queue of signed 32-bit values with constant-time
// reverse.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one command per item (push front, push
// back, pop front, pop back, reverse) with push_value. The rsp channel
// returns status and pop_value for every pop and for every push that finds
// the queue full; successful pushes, reverse and unused codes give nothing.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low.
// Flow: a successful push or a reverse is done in the idle state, so the
// controller stays ready for the next command. A pop reads the entry
// into the registered read data of the entry memory, which then goes to
// the output register or, while that is occupied, to the hold register.
// A full/empty report goes to the hold register, then the output register.
// req_stall is high while a pop's read or a pending result is in flight.
// Stalls: the output register holds its item while rsp_stall is high; pushes
// keep being accepted meanwhile, and the next result-producing item waits
// in the controller until the output register frees up.
// Reset (rst, synchronous): clears pointers, count, direction flag and all
// valid state. Memory contents are not cleared; no pass is needed.
// ----------------------------------------------------------------------------
module deque_with_reverse_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  dqr_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output dqr_pkg::rsp_item_t rsp
);

  dqr_pkg::ctrl_t  ctrl;
  dqr_pkg::stat_t  stat;
  dqr_pkg::state_t state;

  dqr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .command   (req.command),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .state     (state),
    .ctrl      (ctrl)
  );

  dqr_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .push_value (req.push_value),
    .ctrl       (ctrl),
    .stat       (stat),
    .rsp        (rsp)
  );

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> !(rsp_valid && rsp_stall))
    else $error("output register overwritten while stalled");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == dqr_pkg::OP_POP_LOW || ctrl.op == dqr_pkg::OP_POP_HIGH) |-> !stat.empty)
    else $error("pop issued on empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == dqr_pkg::OP_PUSH_LOW || ctrl.op == dqr_pkg::OP_PUSH_HIGH) |-> !stat.full)
    else $error("push issued on full queue");

  // a pop is followed by its memory read cycle
  a_pop_reads: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == dqr_pkg::OP_POP_LOW || ctrl.op == dqr_pkg::OP_POP_HIGH)
      |=> state == dqr_pkg::S_READ)
    else $error("pop not followed by read cycle");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-ended queue with constant-time reverse.
// A short table of directed commands exercises empty pops, value extremes,
// reverse and the unused codes. A random stream with mixed, push-heavy and
// pop-heavy stretches and one run to full follows. Every result is checked
// against a behavioural deque kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;

  localparam int N_ITEMS   = 1750;
  localparam int FILL_AT   = 300;
  localparam int PAUSE_AT  = 1000;
  localparam int QUIET_GAP = 150;
  localparam int MAX_SHOWN = 40;

  // codes the block must ignore
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  localparam int MODE_MIX   = 0;
  localparam int MODE_PUSHY = 1;
  localparam int MODE_POPPY = 2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] val;
    logic               typed;
    logic [1:0]         want_status;
    logic signed [31:0] want_value;
  } dir_row_t;

  localparam int N_ROWS = 24;
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{dqr_pkg::CMD_POP_FRONT,  32'sd0,         1'b1, dqr_pkg::STATUS_EMPTY, 32'sd0},
    '{dqr_pkg::CMD_POP_BACK,   32'sd0,         1'b1, dqr_pkg::STATUS_EMPTY, 32'sd0},
    '{dqr_pkg::CMD_REVERSE,    32'sd0,         1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_POP_FRONT,  -32'sd1,        1'b1, dqr_pkg::STATUS_EMPTY, 32'sd0},
    '{dqr_pkg::CMD_POP_BACK,   -32'sd1,        1'b1, dqr_pkg::STATUS_EMPTY, 32'sd0},
    '{dqr_pkg::CMD_REVERSE,    -32'sd1,        1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_PUSH_BACK,  32'sh8000_0000, 1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_PUSH_FRONT, -32'sd1,        1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_PUSH_BACK,  32'sd0,         1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_POP_FRONT,  32'sd0,         1'b1, dqr_pkg::STATUS_OK,    -32'sd1},
    '{dqr_pkg::CMD_POP_BACK,   32'sd0,         1'b1, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_REVERSE,    32'sd0,         1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_POP_FRONT,  32'sd0,         1'b1, dqr_pkg::STATUS_OK,    32'sh8000_0000},
    '{dqr_pkg::CMD_PUSH_BACK,  32'sh5A5A_5A5A, 1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_PUSH_FRONT, 32'shA5A5_A5A5, 1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{CMD_SPARE_A,             -32'sd1,        1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{CMD_SPARE_B,             32'sh1234_5678, 1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{CMD_SPARE_C,             -32'sd1,        1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_REVERSE,    32'sd0,         1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_POP_BACK,   32'sd0,         1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_POP_FRONT,  32'sd0,         1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_POP_BACK,   32'sd0,         1'b0, dqr_pkg::STATUS_OK,    32'sd0},
    '{dqr_pkg::CMD_POP_FRONT,  32'sd0,         1'b1, dqr_pkg::STATUS_EMPTY, 32'sd0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  dqr_pkg::req_item_t req = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  dqr_pkg::rsp_item_t rsp;

  deque_with_reverse_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // behavioural deque: circular slots, low/high ends, length, flip flag
  logic signed [31:0]        slots [dqr_pkg::DEPTH];
  logic [dqr_pkg::PTR_W-1:0] q_lo = '0;
  logic [dqr_pkg::PTR_W-1:0] q_hi = '0;
  logic [dqr_pkg::CNT_W-1:0] q_len = '0;
  logic                      q_flipped = 1'b0;

  dqr_pkg::rsp_item_t awaited_rsp [$];

  int errors = 0;
  int items_sent = 0;
  int n_popped = 0;
  int n_empty = 0;
  int n_full = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  function automatic logic [dqr_pkg::PTR_W-1:0] ptr_next(
      input logic [dqr_pkg::PTR_W-1:0] p);
    return (p == dqr_pkg::PTR_W'(dqr_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [dqr_pkg::PTR_W-1:0] ptr_prev(
      input logic [dqr_pkg::PTR_W-1:0] p);
    return (p == '0) ? dqr_pkg::PTR_W'(dqr_pkg::DEPTH - 1) : p - 1'b1;
  endfunction

  task automatic predict_deque_cmd(input dqr_pkg::req_item_t item, output bit has_rsp,
                                   output dqr_pkg::rsp_item_t r);
    bit at_lo;
    has_rsp = 1'b0;
    r = '0;
    case (item.command)
      dqr_pkg::CMD_PUSH_FRONT, dqr_pkg::CMD_PUSH_BACK: begin
        if (q_len == dqr_pkg::CNT_W'(dqr_pkg::DEPTH)) begin
          has_rsp = 1'b1;
          r.status = dqr_pkg::STATUS_FULL;
        end else begin
          at_lo = (item.command == dqr_pkg::CMD_PUSH_FRONT) ^ q_flipped;
          if (at_lo) begin
            q_lo = ptr_prev(q_lo);
            slots[q_lo] = item.push_value;
          end else begin
            slots[q_hi] = item.push_value;
            q_hi = ptr_next(q_hi);
          end
          q_len = q_len + 1'b1;
        end
      end
      dqr_pkg::CMD_POP_FRONT, dqr_pkg::CMD_POP_BACK: begin
        has_rsp = 1'b1;
        if (q_len == '0) begin
          r.status = dqr_pkg::STATUS_EMPTY;
        end else begin
          at_lo = (item.command == dqr_pkg::CMD_POP_FRONT) ^ q_flipped;
          r.status = dqr_pkg::STATUS_OK;
          if (at_lo) begin
            r.pop_value = slots[q_lo];
            q_lo = ptr_next(q_lo);
          end else begin
            q_hi = ptr_prev(q_hi);
            r.pop_value = slots[q_hi];
          end
          q_len = q_len - 1'b1;
        end
      end
      dqr_pkg::CMD_REVERSE: q_flipped = ~q_flipped;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (errors < MAX_SHOWN) $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  // append one expected result at the tail
  task automatic await_rsp(input dqr_pkg::rsp_item_t r);
    awaited_rsp.insert(awaited_rsp.size(), r);
  endtask

  task automatic check_result(input dqr_pkg::rsp_item_t got);
    dqr_pkg::rsp_item_t want;
    if (awaited_rsp.size() == 0) begin
      report_mismatch($sformatf("result with nothing awaited, status %0d value %0d",
                                got.status, got.pop_value));
      return;
    end
    want = awaited_rsp.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
    if (got.pop_value !== want.pop_value)
      report_mismatch($sformatf("pop_value %0d, wanted %0d", got.pop_value,
                                want.pop_value));
    case (want.status)
      dqr_pkg::STATUS_OK:    n_popped++;
      dqr_pkg::STATUS_EMPTY: n_empty++;
      default:               n_full++;
    endcase
  endtask

  // result side: check accepted items, stall in random bursts
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) check_result(rsp);
    if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 19) - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  function automatic logic signed [31:0] random_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic dqr_pkg::req_item_t random_cmd(input int mode);
    dqr_pkg::req_item_t it;
    int push_pct;
    int pop_pct;
    int roll;
    case (mode)
      MODE_PUSHY: begin push_pct = 78; pop_pct = 12; end
      MODE_POPPY: begin push_pct = 15; pop_pct = 75; end
      default:    begin push_pct = 44; pop_pct = 44; end
    endcase
    roll = $urandom_range(0, 99);
    it.push_value = random_value();
    if (roll < push_pct)
      it.command = $urandom_range(0, 1) ? dqr_pkg::CMD_PUSH_BACK : dqr_pkg::CMD_PUSH_FRONT;
    else if (roll < push_pct + pop_pct)
      it.command = $urandom_range(0, 1) ? dqr_pkg::CMD_POP_BACK : dqr_pkg::CMD_POP_FRONT;
    else if (roll < 97)
      it.command = dqr_pkg::CMD_REVERSE;
    else case ($urandom_range(0, 2))
      0:       it.command = CMD_SPARE_A;
      1:       it.command = CMD_SPARE_B;
      default: it.command = CMD_SPARE_C;
    endcase
    return it;
  endfunction

  task automatic pick_idle_levels();
    case (quiet ? 0 : $urandom_range(0, 3))
      0:       begin gap_pct = 0;  stall_pct = 0;  end
      1:       begin gap_pct = 10; stall_pct = 5;  end
      2:       begin gap_pct = 30; stall_pct = 15; end
      default: begin gap_pct = 5;  stall_pct = 25; end
    endcase
  endtask

  // drive one item, wait for it to be taken, then log what it should produce
  task automatic send_item(input dqr_pkg::req_item_t item, input bit typed,
                           input dqr_pkg::rsp_item_t want);
    bit has_rsp;
    dqr_pkg::rsp_item_t r;
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    predict_deque_cmd(item, has_rsp, r);
    if (typed) await_rsp(want);
    else if (has_rsp) await_rsp(r);
    if (item.command <= dqr_pkg::CMD_REVERSE) items_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic push_random();
    dqr_pkg::req_item_t it;
    it.command = $urandom_range(0, 1) ? dqr_pkg::CMD_PUSH_BACK : dqr_pkg::CMD_PUSH_FRONT;
    it.push_value = random_value();
    send_item(it, 1'b0, '0);
  endtask

  initial begin
    dqr_pkg::req_item_t it;
    dqr_pkg::rsp_item_t want;
    bit filled;
    bit paused;
    int mode;
    int len;
    filled = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pick_idle_levels();
    for (int i = 0; i < N_ROWS; i++) begin
      it.command = DIR_ROWS[i].cmd;
      it.push_value = DIR_ROWS[i].val;
      want.status = DIR_ROWS[i].want_status;
      want.pop_value = DIR_ROWS[i].want_value;
      send_item(it, DIR_ROWS[i].typed, want);
    end
    wait_for_results();

    while (items_sent < N_ITEMS) begin
      pick_idle_levels();
      if (!filled && items_sent >= FILL_AT) begin
        // run up to full, then knock on both ends, also after a reverse
        while (q_len < dqr_pkg::CNT_W'(dqr_pkg::DEPTH)) begin
          if ($urandom_range(0, 19) == 0)
            send_item('{dqr_pkg::CMD_REVERSE, random_value()}, 1'b0, '0);
          else push_random();
        end
        send_item('{dqr_pkg::CMD_PUSH_FRONT, random_value()}, 1'b0, '0);
        send_item('{dqr_pkg::CMD_PUSH_BACK, random_value()}, 1'b0, '0);
        send_item('{dqr_pkg::CMD_REVERSE, random_value()}, 1'b0, '0);
        push_random();
        filled = 1'b1;
      end else begin
        mode = $urandom_range(MODE_MIX, MODE_POPPY);
        len = $urandom_range(10, 80);
        repeat (len) send_item(random_cmd(mode), 1'b0, '0);
      end
      if (!paused && items_sent >= PAUSE_AT) begin
        wait_for_results();
        paused = 1'b1;
      end
      if (items_sent >= N_ITEMS - QUIET_GAP) quiet = 1'b1;
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    $display("ran %0d commands: %0d values popped, %0d empty pops, %0d full pushes",
             items_sent, n_popped, n_empty, n_full);
    $display("covered both ends, reverse, value extremes, ignored codes and one fill");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still awaited", awaited_rsp.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/dqr_pkg.sv
rtl/dqr_ctrl.sv
rtl/dqr_dpath.sv
rtl/deque_with_reverse_top.sv
verif/testbench.sv
